/* hdl/weighted_image_blend_dither_macros.svh */
// assertion helpers used by the blend merge rtl
`ifndef WEIGHTED_IMAGE_BLEND_DITHER_MACROS_SVH
`define WEIGHTED_IMAGE_BLEND_DITHER_MACROS_SVH

// same-cycle implication, quiet during reset
`define WIBD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wibd check failed");

// next-cycle implication, quiet during reset
`define WIBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wibd check failed");

`endif

/* hdl/wibd_pkg.sv */
`default_nettype none
package wibd_pkg;

    // block geometry
    localparam int NUM_IMAGES = 4;
    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 12;
    localparam int IDX_W      = 4;
    localparam int PROD_W     = WEIGHT_W + PIX_W;
    localparam int SUM_W      = PROD_W + $clog2(NUM_IMAGES) + 1;
    localparam int RND_W      = SUM_W - FRAC_W;

    // rounding offset of one half in units of 2^-FRAC_W
    localparam logic [SUM_W-1:0] FRAC_HALF =
        {{(SUM_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MIN = '0;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WEIGHT_ZERO  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_WEIGHT_ONE   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_WEIGHT_TWO   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_WEIGHT_THREE = IDX_W'(3);

    // what one lane hands to the merge stage
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     nonzero;
        logic [PIX_W-1:0]         pixel;
    } lane_t;

endpackage
`default_nettype wire

/* hdl/wibd_lane.sv */
`default_nettype none
module wibd_lane
    import wibd_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       ld,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    input  wire logic [PIX_W-1:0]           pixel,
    output lane_t                           lane
);

    logic signed [PROD_W:0] prod_full;
    lane_t                  lane_reg;

    // weight times byte, byte taken as non-negative
    assign prod_full = weight * $signed({1'b0, pixel});

    // stage one register
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            lane_reg.product <= prod_full[PROD_W-1:0];
            lane_reg.nonzero <= (weight != '0);
            lane_reg.pixel   <= pixel;
        end
    end

    assign lane = lane_reg;

endmodule
`default_nettype wire

/* hdl/wibd_merge.sv */
`default_nettype none
`include "weighted_image_blend_dither_macros.svh"
module wibd_merge
    import wibd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s1_valid,
    input  wire lane_t [NUM_IMAGES-1:0] lanes,
    input  wire logic                  out_ready,
    output logic                       can_take,
    output logic                       out_valid,
    output logic [PIX_W-1:0]           blended_byte,
    output logic                       was_clamped
);

    logic                    out_valid_reg;
    logic [PIX_W-1:0]        byte_reg;
    logic                    clamp_reg;
    logic [FRAC_W-1:0]       residual_reg;
    logic [FRAC_W-1:0]       residual_next;

    logic                    advance;
    logic                    single;
    logic [PIX_W-1:0]        bypass_pix;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        sum_half;
    logic [RND_W-1:0]        rounded;
    logic [PIX_W-1:0]        sat_byte;
    logic                    sat_flag;
    logic [NUM_IMAGES-1:0]   nz_vec;

    assign can_take = !out_valid_reg || out_ready;
    assign advance  = s1_valid && can_take;

    // lone nonzero weight passes its byte straight through
    always_comb
    begin
        bypass_pix = '0;
        for (int i = 0; i < NUM_IMAGES; i++)
        begin
            nz_vec[i] = lanes[i].nonzero;
            if (lanes[i].nonzero)
                bypass_pix = bypass_pix | lanes[i].pixel;
        end
        single = ($countones(nz_vec) == 1);
    end

    // weighted sum plus kept residual, round half up
    always_comb
    begin
        sum = {{(SUM_W-FRAC_W){residual_reg[FRAC_W-1]}}, residual_reg};
        for (int i = 0; i < NUM_IMAGES; i++)
            sum = sum + {{(SUM_W-PROD_W){lanes[i].product[PROD_W-1]}}, lanes[i].product};
        sum_half      = sum + FRAC_HALF;
        rounded       = sum_half[SUM_W-1:FRAC_W];
        residual_next = sum[FRAC_W-1:0];
    end

    // saturate to byte range
    always_comb
    begin
        if (rounded[RND_W-1])
        begin
            sat_byte = PIX_MIN;
            sat_flag = 1'b1;
        end
        else if (rounded[RND_W-2:PIX_W] != '0)
        begin
            sat_byte = PIX_MAX;
            sat_flag = 1'b1;
        end
        else
        begin
            sat_byte = rounded[PIX_W-1:0];
            sat_flag = 1'b0;
        end
    end

    // output valid and residual state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            residual_reg  <= '0;
        end
        else
        begin
            if (can_take)
                out_valid_reg <= s1_valid;
            if (advance && !single)
                residual_reg <= residual_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg  <= single ? bypass_pix : sat_byte;
            clamp_reg <= single ? 1'b0 : sat_flag;
        end
    end

    assign out_valid    = out_valid_reg;
    assign blended_byte = byte_reg;
    assign was_clamped  = clamp_reg;

    // checks
    `WIBD_ASSERT_NOW(a_clamp_at_rail, clk, rst_n, out_valid_reg && clamp_reg,
        byte_reg == PIX_MIN || byte_reg == PIX_MAX)
    `WIBD_ASSERT_NEXT(a_residual_idle, clk, rst_n, !advance, $stable(residual_reg))
    `WIBD_ASSERT_NEXT(a_residual_bypass, clk, rst_n, advance && single,
        $stable(residual_reg))
    `WIBD_ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid_reg)

endmodule
`default_nettype wire

/* hdl/weighted_image_blend_dither.sv */
`default_nettype none
// Blends one channel byte from each of four source images per beat: the bytes
// are multiplied by signed Q3.12 weights, summed with a carried rounding
// residual, rounded to nearest (half up), clamped to 0..255 with was_clamped
// flagging saturation, and the fractional remainder kept for the next beat.
// The residual is cleared only by reset. When exactly one weight is nonzero
// that image's byte passes unchanged and the residual is left alone. Weights
// must be written through cfg_wr_en/cfg_wr_index/cfg_wr_data only while the
// block is idle, which the block does not enforce; indexes beyond three are
// ignored. One beat per clock unless out_ready stalls; beats are registered
// in the lanes, then the merge stage, whose adder closes the residual feedback.
module weighted_image_blend_dither
    import wibd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [IDX_W-1:0]    cfg_wr_index,
    input  wire logic [WEIGHT_W-1:0] cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [PIX_W-1:0]    pixel_zero,
    input  wire logic [PIX_W-1:0]    pixel_one,
    input  wire logic [PIX_W-1:0]    pixel_two,
    input  wire logic [PIX_W-1:0]    pixel_three,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [PIX_W-1:0]         blended_byte,
    output logic                     was_clamped
);

    logic signed [WEIGHT_W-1:0] weight_reg [NUM_IMAGES];
    logic [PIX_W-1:0]           pixel_arr  [NUM_IMAGES];
    lane_t [NUM_IMAGES-1:0]     lanes;
    logic                       s1_valid_reg;
    logic                       can_take;
    logic                       ld;

    // weight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_IMAGES; i++)
                weight_reg[i] <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_WEIGHT_ZERO:  weight_reg[0] <= cfg_wr_data;
                REG_WEIGHT_ONE:   weight_reg[1] <= cfg_wr_data;
                REG_WEIGHT_TWO:   weight_reg[2] <= cfg_wr_data;
                REG_WEIGHT_THREE: weight_reg[3] <= cfg_wr_data;
                default:          ;
            endcase
        end
    end

    // input beat handshake and stage one valid
    assign in_ready = !s1_valid_reg || can_take;
    assign ld       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    assign pixel_arr[0] = pixel_zero;
    assign pixel_arr[1] = pixel_one;
    assign pixel_arr[2] = pixel_two;
    assign pixel_arr[3] = pixel_three;

    // one multiplier lane per image
    for (genvar g = 0; g < NUM_IMAGES; g++)
    begin : g_lane
        wibd_lane u_lane (
            .clk    (clk),
            .ld     (ld),
            .weight (weight_reg[g]),
            .pixel  (pixel_arr[g]),
            .lane   (lanes[g])
        );
    end

    // merge, round, clamp and output register
    wibd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid_reg),
        .lanes        (lanes),
        .out_ready    (out_ready),
        .can_take     (can_take),
        .out_valid    (out_valid),
        .blended_byte (blended_byte),
        .was_clamped  (was_clamped)
    );

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;
    import wibd_pkg::*;

    localparam int Q_ONE         = 1 << FRAC_W;
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BEATS   = 100;
    localparam int PHASES_PER_MODE = 5;
    localparam int NUM_MIX_KINDS = 6;
    localparam int FIRST_UNUSED_REG = int'(REG_WEIGHT_THREE) + 1;

    localparam logic [IDX_W-1:0] WEIGHT_REG [NUM_IMAGES] =
        '{REG_WEIGHT_ZERO, REG_WEIGHT_ONE, REG_WEIGHT_TWO, REG_WEIGHT_THREE};
    localparam logic [WEIGHT_W-1:0] EXTREME_WEIGHTS [5] =
        '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};

    typedef enum int {
        MIX_NORMALISED,
        MIX_SHARPEN,
        MIX_SINGLE,
        MIX_NONE,
        MIX_RAW,
        MIX_EXTREME
    } mix_kind_e;

    typedef logic [0:NUM_IMAGES-1][WEIGHT_W-1:0] weight_set_t;
    typedef logic [0:NUM_IMAGES-1][PIX_W-1:0]    pixel_set_t;

    typedef struct packed {
        logic [PIX_W-1:0] blended;
        logic             clamped;
    } blend_beat_t;

    typedef struct packed {
        weight_set_t      weights;
        pixel_set_t       pixels;
        logic             stray;
        logic             typed;
        logic [PIX_W-1:0] blended;
        logic             clamped;
    } directed_row_t;

    // directed rows: weights w0..w3, pixels p0..p3, writes beyond the list,
    // whether the expectation is typed in, then that expectation
    localparam int NUM_DIRECTED = 18;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // all weights zero after reset
        '{{16'h0000, 16'h0000, 16'h0000, 16'h0000}, {8'h00, 8'h00, 8'h00, 8'h00},
          1'b0, 1'b1, 8'h00, 1'b0},
        '{{16'h0000, 16'h0000, 16'h0000, 16'h0000}, {8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b0, 1'b1, 8'h00, 1'b0},
        // one nonzero weight copies that byte, stray writes must not land
        '{{16'h1000, 16'h0000, 16'h0000, 16'h0000}, {8'hA5, 8'h5A, 8'hFF, 8'h00},
          1'b1, 1'b1, 8'hA5, 1'b0},
        '{{16'h0000, 16'h0000, 16'h8000, 16'h0000}, {8'h12, 8'h34, 8'hFF, 8'h56},
          1'b0, 1'b1, 8'hFF, 1'b0},
        '{{16'h0000, 16'h0000, 16'h0000, 16'h0001}, {8'h00, 8'hFF, 8'hFF, 8'h80},
          1'b0, 1'b1, 8'h80, 1'b0},
        '{{16'h0000, 16'h7FFF, 16'h0000, 16'h0000}, {8'hFF, 8'h00, 8'hFF, 8'hFF},
          1'b0, 1'b1, 8'h00, 1'b0},
        // saturation at both ends
        '{{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, {8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b0, 1'b1, 8'hFF, 1'b1},
        '{{16'h8000, 16'h8000, 16'h8000, 16'h8000}, {8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b0, 1'b1, 8'h00, 1'b1},
        '{{16'h8000, 16'h8000, 16'h8000, 16'h8000}, {8'h00, 8'h00, 8'h00, 8'h00},
          1'b0, 1'b0, 8'h00, 1'b0},
        // half-way ties and residual carry
        '{{16'h0800, 16'h0800, 16'h0000, 16'h0000}, {8'h01, 8'h00, 8'h00, 8'h00},
          1'b0, 1'b0, 8'h00, 1'b0},
        '{{16'h0800, 16'h0800, 16'h0000, 16'h0000}, {8'h01, 8'h00, 8'h00, 8'h00},
          1'b0, 1'b0, 8'h00, 1'b0},
        '{{16'h0400, 16'h0400, 16'h0400, 16'h0400}, {8'h0A, 8'h14, 8'h1E, 8'h29},
          1'b0, 1'b0, 8'h00, 1'b0},
        '{{16'h0555, 16'h0555, 16'h0556, 16'h0000}, {8'h01, 8'h01, 8'h02, 8'hFF},
          1'b0, 1'b0, 8'h00, 1'b0},
        '{{16'hF800, 16'h1800, 16'h0000, 16'h0000}, {8'hFF, 8'hFF, 8'h00, 8'h00},
          1'b0, 1'b0, 8'h00, 1'b0},
        '{{16'h1000, 16'h1000, 16'h0000, 16'h0000}, {8'hC8, 8'h64, 8'h00, 8'h00},
          1'b0, 1'b1, 8'hFF, 1'b1},
        '{{16'h1000, 16'hF000, 16'h0000, 16'h0000}, {8'h00, 8'h01, 8'hFF, 8'hFF},
          1'b0, 1'b1, 8'h00, 1'b1},
        '{{16'h0400, 16'h0400, 16'h0400, 16'h0400}, {8'h55, 8'hAA, 8'h55, 8'hAA},
          1'b0, 1'b0, 8'h00, 1'b0},
        '{{16'h0000, 16'h0000, 16'h2000, 16'hF000}, {8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [IDX_W-1:0]    cfg_wr_index = '0;
    logic [WEIGHT_W-1:0] cfg_wr_data  = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [PIX_W-1:0]    pixel_zero   = '0;
    logic [PIX_W-1:0]    pixel_one    = '0;
    logic [PIX_W-1:0]    pixel_two    = '0;
    logic [PIX_W-1:0]    pixel_three  = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [PIX_W-1:0]    blended_byte;
    logic                was_clamped;

    // own copy of the weights and the carried residual
    weight_set_t               weight_reg   = '0;
    logic signed [FRAC_W-1:0]  residual_reg = '0;

    blend_beat_t pending_blend_q [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    weighted_image_blend_dither dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_zero   (pixel_zero),
        .pixel_one    (pixel_one),
        .pixel_two    (pixel_two),
        .pixel_three  (pixel_three),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .blended_byte (blended_byte),
        .was_clamped  (was_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // blended byte for one beat, advancing the residual
    function automatic blend_beat_t predict_blend(input pixel_set_t pix);
        blend_beat_t beat;
        int          n_active;
        int          only_img;
        longint      acc;
        longint      rounded;
        n_active = 0;
        only_img = 0;
        for (int i = 0; i < NUM_IMAGES; i++)
        begin
            if (weight_reg[i] != '0)
            begin
                n_active++;
                only_img = i;
            end
        end
        // a lone weight passes its byte through untouched
        if (n_active == 1)
        begin
            beat.blended = pix[only_img];
            beat.clamped = 1'b0;
            return beat;
        end
        acc = longint'(residual_reg);
        for (int i = 0; i < NUM_IMAGES; i++)
            acc += longint'($signed(weight_reg[i])) * longint'(pix[i]);
        rounded      = (acc + longint'(Q_ONE / 2)) >>> FRAC_W;
        residual_reg = FRAC_W'(acc - (rounded <<< FRAC_W));
        if (rounded < 0)
        begin
            beat.blended = PIX_MIN;
            beat.clamped = 1'b1;
        end
        else if (rounded > longint'(PIX_MAX))
        begin
            beat.blended = PIX_MAX;
            beat.clamped = 1'b1;
        end
        else
        begin
            beat.blended = PIX_W'(rounded);
            beat.clamped = 1'b0;
        end
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic check_blend_beat();
        blend_beat_t want;
        if (pending_blend_q.size() == 0)
        begin
            report_mismatch("beat with nothing pending", '1, blended_byte);
            return;
        end
        want = pending_blend_q.pop_front();
        if (blended_byte !== want.blended)
            report_mismatch("blended_byte", want.blended, blended_byte);
        if (was_clamped !== want.clamped)
            report_mismatch("was_clamped", want.clamped, was_clamped);
    endtask

    // result side: check accepted beats and stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_blend_beat();
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    // one pixel beat, with an optional gap before it
    task automatic send_pixels(input pixel_set_t pix, input logic typed,
                               input blend_beat_t typed_beat);
        blend_beat_t predicted;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        pixel_zero  <= pix[0];
        pixel_one   <= pix[1];
        pixel_two   <= pix[2];
        pixel_three <= pix[3];
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_blend(pix);
        pending_blend_q.push_back(typed ? typed_beat : predicted);
    endtask

    // stop sending and let every pending beat come out
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_blend_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge clk);
        for (int j = 0; j < NUM_IMAGES; j++)
        begin
            if (idx == WEIGHT_REG[j])
                weight_reg[j] = data;
        end
    endtask

    task automatic apply_weights(input weight_set_t w, input logic stray);
        drain_pipeline();
        for (int i = 0; i < NUM_IMAGES; i++)
            write_reg(WEIGHT_REG[i], w[i]);
        if (stray)
        begin
            for (int k = FIRST_UNUSED_REG; k < (1 << IDX_W); k++)
                write_reg(IDX_W'(k), WEIGHT_W'($urandom_range(1, 65535)));
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic weight_set_t make_weights(input mix_kind_e kind);
        weight_set_t w;
        logic [NUM_IMAGES-1:0] mask;
        int raw [NUM_IMAGES];
        int total;
        w     = '0;
        mask  = NUM_IMAGES'($urandom_range(1, (1 << NUM_IMAGES) - 1));
        total = 0;
        case (kind)
            // positive weights summing to about one
            MIX_NORMALISED:
            begin
                for (int i = 0; i < NUM_IMAGES; i++)
                begin
                    raw[i] = mask[i] ? int'($urandom_range(1, Q_ONE)) : 0;
                    total += raw[i];
                end
                for (int i = 0; i < NUM_IMAGES; i++)
                    w[i] = WEIGHT_W'((raw[i] * Q_ONE) / total);
            end
            MIX_SHARPEN:
            begin
                for (int i = 0; i < NUM_IMAGES; i++)
                    if (mask[i])
                        w[i] = WEIGHT_W'(int'($urandom_range(0, 3 * Q_ONE)) - Q_ONE);
            end
            MIX_SINGLE:
                w[$urandom_range(0, NUM_IMAGES - 1)] = WEIGHT_W'($urandom_range(1, 65535));
            MIX_NONE:
                w = '0;
            MIX_RAW:
            begin
                for (int i = 0; i < NUM_IMAGES; i++)
                    if (mask[i])
                        w[i] = WEIGHT_W'($urandom_range(0, 65535));
            end
            default:
            begin
                for (int i = 0; i < NUM_IMAGES; i++)
                    w[i] = EXTREME_WEIGHTS[$urandom_range(0, 4)];
            end
        endcase
        return w;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        directed_row_t row;
        blend_beat_t   typed_beat;
        pixel_set_t    pix;
        mix_kind_e     kind;
        int            phase;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.weights != weight_reg || row.stray)
                apply_weights(row.weights, row.stray);
            typed_beat = '{blended: row.blended, clamped: row.clamped};
            send_pixels(row.pixels, row.typed, typed_beat);
        end

        // random phases under three idling patterns
        phase = 0;
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 50 : 0;
            recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 20 : 0;
            for (int p = 0; p < PHASES_PER_MODE; p++)
            begin
                kind = mix_kind_e'(phase % NUM_MIX_KINDS);
                apply_weights(make_weights(kind), ($urandom_range(0, 3) == 0));
                for (int n = 0; n < PHASE_BEATS; n++)
                begin
                    // hold off mid-phase until the pipe is empty
                    if (n == PHASE_BEATS / 2)
                        drain_pipeline();
                    for (int i = 0; i < NUM_IMAGES; i++)
                        pix[i] = random_pixel();
                    send_pixels(pix, 1'b0, '0);
                end
                phase++;
            end
        end

        drain_pipeline();
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
`default_nettype wire
